// ----- sv/mi3_pkg.sv -----
package mi3_pkg;

    localparam int NL   = 9;    // adjugate / inverse elements
    localparam int DW   = 98;   // determinant and remainder width
    localparam int QW   = 32;   // quotient bits kept
    localparam int DIVN = QW;   // one quotient bit per stage

    typedef struct packed {
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a02;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
        logic signed [31:0] a12;
        logic signed [31:0] a20;
        logic signed [31:0] a21;
        logic signed [31:0] a22;
    } mat_t;

    typedef struct packed {
        logic signed [31:0] inv00;
        logic signed [31:0] inv01;
        logic signed [31:0] inv02;
        logic signed [31:0] inv10;
        logic signed [31:0] inv11;
        logic signed [31:0] inv12;
        logic signed [31:0] inv20;
        logic signed [31:0] inv21;
        logic signed [31:0] inv22;
        logic signed [31:0] det_value;
        logic               singular;
        logic               overflow;
    } result_t;

    // travels alongside the divider lanes
    typedef struct packed {
        logic [DW-1:0] dmag;
        logic          singular;
        logic [31:0]   detv;
        logic          dovf;
        logic [NL-1:0] neg;
        logic [NL-1:0] zero;
        logic [NL-1:0] big;
    } side_t;

endpackage

// ----- sv/matrix3x3_inverse_core.sv -----
// 3x3 matrix inverse by the adjugate, Q16.16 in and out. A request is taken
// whenever start is high (busy is always low), one per clock, and its result
// appears on result with done high for one cycle, after the stages of minors,
// adjugate and determinant, then 32 pipelined restoring division stages (one
// quotient bit per stage, nine lanes), then one output register. The receiver
// cannot stall; results must be taken as they come.
module matrix3x3_inverse_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mi3_pkg::mat_t    a,
    output logic             done,
    output mi3_pkg::result_t result
);
    import mi3_pkg::*;

    localparam int NST = 6 + DIVN + 1;

    logic [NST-1:0] vld_reg;

    logic signed [31:0] m [3][3];
    logic signed [63:0] pa_next [NL];
    logic signed [63:0] pb_next [NL];
    logic signed [63:0] pa_reg [NL];
    logic signed [63:0] pb_reg [NL];
    logic signed [31:0] m0_reg [3];
    logic signed [31:0] m0b_reg [3];
    logic signed [63:0] adj_reg [NL];
    logic signed [63:0] adj3_reg [NL];
    logic signed [63:0] adj4_reg [NL];
    logic signed [63:0] adj5_reg [NL];
    logic signed [64:0] plo_reg [3];
    logic signed [63:0] phi_reg [3];
    logic signed [DW-1:0] term_reg [3];
    logic signed [DW-1:0] det_reg;

    side_t         side_next;
    logic [DW-1:0] rem_next [NL];
    side_t         side_reg [DIVN+1];
    logic [DW-1:0] rem_reg [DIVN+1][NL];
    logic [QW-1:0] quo_reg [DIVN+1][NL];

    result_t res_next;
    result_t res_reg;

    assign busy = 1'b0;

    always_comb
    begin
        m[0][0] = a.a00; m[0][1] = a.a01; m[0][2] = a.a02;
        m[1][0] = a.a10; m[1][1] = a.a11; m[1][2] = a.a12;
        m[2][0] = a.a20; m[2][1] = a.a21; m[2][2] = a.a22;
    end

    // adj(i,j) uses the minor dropping row j and column i
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                pa_next[i*3+j] = m[(j == 0) ? 1 : 0][(i == 0) ? 1 : 0]
                               * m[(j == 2) ? 1 : 2][(i == 2) ? 1 : 2];
                pb_next[i*3+j] = m[(j == 0) ? 1 : 0][(i == 2) ? 1 : 2]
                               * m[(j == 2) ? 1 : 2][(i == 0) ? 1 : 0];
            end
        end
    end

    always_comb
    begin
        logic [63:0]     am;
        logic signed [65:0] sh;
        side_next.dmag     = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        side_next.singular = (det_reg == '0);
        sh = det_reg[DW-1:32];
        side_next.dovf = !((&sh[65:31]) || !(|sh[65:31]));
        side_next.detv = side_next.dovf ? (sh[65] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                        : sh[31:0];
        for (int l = 0; l < NL; l++) begin
            am = adj5_reg[l][63] ? 64'(-adj5_reg[l]) : adj5_reg[l];
            side_next.neg[l]  = adj5_reg[l][63] ^ det_reg[DW-1];
            side_next.zero[l] = (adj5_reg[l] == '0);
            side_next.big[l]  = ({{(DW-64){1'b0}}, am} >= side_next.dmag);
            rem_next[l] = {{(DW-64){1'b0}}, am};
        end
    end

    always_comb
    begin
        logic [QW-1:0] q;
        logic          ov;
        logic [31:0]   v [NL];
        side_t         sd;
        sd = side_reg[DIVN];
        ov = 1'b0;
        for (int l = 0; l < NL; l++) begin
            q = quo_reg[DIVN][l];
            if (sd.singular || sd.zero[l]) begin
                v[l] = '0;
            end else if (!sd.neg[l]) begin
                if (sd.big[l] || q > 32'h7FFF_FFFF) begin
                    v[l] = 32'h7FFF_FFFF;
                    ov = 1'b1;
                end else begin
                    v[l] = q;
                end
            end else begin
                if (sd.big[l] || q > 32'h8000_0000) begin
                    v[l] = 32'h8000_0000;
                    ov = 1'b1;
                end else begin
                    v[l] = 32'(-q);
                end
            end
        end
        res_next.inv00 = v[0]; res_next.inv01 = v[1]; res_next.inv02 = v[2];
        res_next.inv10 = v[3]; res_next.inv11 = v[4]; res_next.inv12 = v[5];
        res_next.inv20 = v[6]; res_next.inv21 = v[7]; res_next.inv22 = v[8];
        res_next.det_value = sd.singular ? '0 : sd.detv;
        res_next.singular  = sd.singular;
        res_next.overflow  = !sd.singular && (ov || sd.dovf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[NST-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        logic [DW-1:0] r2;
        for (int l = 0; l < NL; l++) begin
            pa_reg[l]   <= pa_next[l];
            pb_reg[l]   <= pb_next[l];
            adj_reg[l]  <= (l % 2 == 1) ? pb_reg[l] - pa_reg[l] : pa_reg[l] - pb_reg[l];
            adj3_reg[l] <= adj_reg[l];
            adj4_reg[l] <= adj3_reg[l];
            adj5_reg[l] <= adj4_reg[l];
        end
        for (int j = 0; j < 3; j++) begin
            m0_reg[j]   <= m[0][j];
            m0b_reg[j]  <= m0_reg[j];
            plo_reg[j]  <= m0b_reg[j] * $signed({1'b0, adj_reg[j*3][31:0]});
            phi_reg[j]  <= m0b_reg[j] * $signed(adj_reg[j*3][63:32]);
            term_reg[j] <= (DW'(phi_reg[j]) <<< 32) + DW'(plo_reg[j]);
        end
        det_reg <= term_reg[0] + term_reg[1] + term_reg[2];

        side_reg[0] <= side_next;
        for (int l = 0; l < NL; l++) begin
            rem_reg[0][l] <= rem_next[l];
            quo_reg[0][l] <= '0;
        end
        for (int s = 0; s < DIVN; s++) begin
            side_reg[s+1] <= side_reg[s];
            for (int l = 0; l < NL; l++) begin
                r2 = {rem_reg[s][l][DW-2:0], 1'b0};
                if (r2 >= side_reg[s].dmag) begin
                    rem_reg[s+1][l] <= r2 - side_reg[s].dmag;
                    quo_reg[s+1][l] <= {quo_reg[s][l][QW-2:0], 1'b1};
                end else begin
                    rem_reg[s+1][l] <= r2;
                    quo_reg[s+1][l] <= {quo_reg[s][l][QW-2:0], 1'b0};
                end
            end
        end
        res_reg <= res_next;
    end

    assign done   = vld_reg[NST-1];
    assign result = res_reg;

endmodule

// ----- dv/matrix3x3_inverse_core_tb.sv -----
module matrix3x3_inverse_core_tb;
    import mi3_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    mat_t    a;
    logic    done;
    result_t result;

    result_t pending_inv[$];
    int      n_errors;

    matrix3x3_inverse_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .a      (a),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("Simulation FAILED");
        $finish;
    end

    // exact adjugate inverse, truncating divide, saturation
    function automatic result_t inverse_of(mat_t m);
        result_t             r;
        logic signed [63:0]  e [3][3];
        logic signed [127:0] adj [3][3];
        logic signed [127:0] det;
        logic signed [127:0] q;
        logic signed [127:0] sh;
        logic signed [31:0]  o [9];
        logic                ovf;
        int                  r1, r2, c1, c2;
        e[0][0] = m.a00; e[0][1] = m.a01; e[0][2] = m.a02;
        e[1][0] = m.a10; e[1][1] = m.a11; e[1][2] = m.a12;
        e[2][0] = m.a20; e[2][1] = m.a21; e[2][2] = m.a22;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                // minor dropping row j, column i
                r1 = (j == 0) ? 1 : 0; r2 = (j == 2) ? 1 : 2;
                c1 = (i == 0) ? 1 : 0; c2 = (i == 2) ? 1 : 2;
                adj[i][j] = e[r1][c1] * e[r2][c2] - e[r1][c2] * e[r2][c1];
                if ((i + j) % 2 == 1)
                    adj[i][j] = -adj[i][j];
            end
        det = e[0][0] * adj[0][0] + e[0][1] * adj[1][0] + e[0][2] * adj[2][0];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        ovf = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            q = (adj[k / 3][k % 3] <<< 32) / det;
            if (q > 128'sd2147483647)
            begin
                o[k] = 32'h7fffffff; ovf = 1'b1;
            end
            else if (q < -128'sd2147483648)
            begin
                o[k] = 32'h80000000; ovf = 1'b1;
            end
            else
                o[k] = q[31:0];
        end
        sh = det >>> 32;
        if (sh > 128'sd2147483647)
        begin
            r.det_value = 32'h7fffffff; ovf = 1'b1;
        end
        else if (sh < -128'sd2147483648)
        begin
            r.det_value = 32'h80000000; ovf = 1'b1;
        end
        else
            r.det_value = sh[31:0];
        r.inv00 = o[0]; r.inv01 = o[1]; r.inv02 = o[2];
        r.inv10 = o[3]; r.inv11 = o[4]; r.inv12 = o[5];
        r.inv20 = o[6]; r.inv21 = o[7]; r.inv22 = o[8];
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3, 4: return $urandom;
            5, 6: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            7: return 32'($signed($urandom_range(0, 64)) - 32) << 16;
            default: return 32'($signed($urandom_range(0, 4096)) - 2048) << 8;
        endcase
    endfunction

    function automatic mat_t rand_matrix();
        mat_t m;
        int   mode;
        m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
             rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        mode = $urandom_range(0, 9);
        // rank-deficient: duplicate or zero a row / column; or keep only the diagonal
        if (mode == 0)
            {m.a20, m.a21, m.a22} = {m.a00, m.a01, m.a02};
        else if (mode == 1)
            {m.a01, m.a11, m.a21} = {m.a00, m.a10, m.a20};
        else if (mode == 2)
            {m.a10, m.a11, m.a12} = '0;
        else if (mode == 3)
            {m.a01, m.a02, m.a10, m.a12, m.a20, m.a21} = '0;
        return m;
    endfunction

    task automatic issue(input mat_t m, input logic use_expected,
                         input result_t expected_r);
        int gap;
        if ($urandom_range(0, 2) == 0)
        begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        a     <= m;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_inv.push_back(use_expected ? expected_r : inverse_of(m));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_inv.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                n_errors++;
            end
            else
            begin
                want = pending_inv.pop_front();
                if (result !== want)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time,
                             want, result);
                    n_errors++;
                end
            end
        end
    end

    typedef struct {
        mat_t    m;
        logic    typed;
        result_t r;
    } stim_row_t;

    localparam logic [31:0] ONE = 32'h00010000;
    localparam logic [31:0] MX  = 32'h7fffffff;
    localparam logic [31:0] MN  = 32'h80000000;

    stim_row_t directed[] = '{
        '{'0, 1'b1, result_t'({320'h0, 1'b1, 1'b0})},
        '{{ONE, 32'h0, 32'h0, 32'h0, ONE, 32'h0, 32'h0, 32'h0, ONE}, 1'b1,
          '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, 1'b0, 1'b0}},
        '{{MX, 32'h0, 32'h0, 32'h0, MX, 32'h0, 32'h0, 32'h0, MX}, 1'b0, '0},
        '{{MN, 32'h0, 32'h0, 32'h0, MN, 32'h0, 32'h0, 32'h0, MN}, 1'b0, '0},
        '{{32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1},
          1'b0, '0},
        '{{MX, MX, MX, MX, MX, MX, MX, MX, MX}, 1'b1, result_t'({320'h0, 2'b10})},
        '{{MN, MX, MN, MX, MN, MX, MN, MX, MX}, 1'b0, '0},
        '{{MX, MN, 32'h0, MN, MX, 32'h0, 32'h0, 32'h0, MN}, 1'b0, '0},
        '{{32'hffff0000, 32'h0, 32'h0, 32'h0, 32'h20000, 32'h0, 32'h0, 32'h0,
           32'h8000}, 1'b0, '0},
        '{{ONE, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000,
           32'h70000, 32'h80000, 32'ha0000}, 1'b0, '0},
        '{{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
           32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff}, 1'b0, '0},
        '{{32'h55555555, 32'haaaaaaaa, 32'h0, 32'h0, 32'h55555555, 32'haaaaaaaa,
           32'haaaaaaaa, 32'h0, 32'h55555555}, 1'b0, '0}
    };

    initial
    begin
        n_errors = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        a        = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[k])
            issue(directed[k].m, directed[k].typed, directed[k].r);
        repeat (1540)
            issue(rand_matrix(), 1'b0, '0);
        start <= 1'b0;
        fork
            begin
                while (pending_inv.size() != 0)
                    @(posedge clk);
            end
            begin
                repeat (5000) @(posedge clk);
                n_errors++;
                $display("%0t: timeout, %0d requests outstanding", $time,
                         pending_inv.size());
            end
        join_any
        disable fork;
        repeat (60) @(posedge clk);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
